>>> src/slwc_pkg.sv
// ----------------------------------------------------------------------------
// slwc_pkg: shared constants and types for the scaled log block
// widths, register indexes, reset values and the pipeline sideband type
// ----------------------------------------------------------------------------
package slwc_pkg;

    // magnitude width, unsigned Q(IN_WIDTH-16).16, valid range 16..48
    localparam int IN_WIDTH   = 32;
    localparam int FRAC_BITS  = 24;
    localparam int MSB_W      = $clog2(IN_WIDTH);
    // normalized mantissa keeps its leading one at bit 31
    localparam int Y_W        = 32;
    localparam int MAX_INT    = ((IN_WIDTH - 17) > 16) ? (IN_WIDTH - 17) : 16;
    localparam int INT_W      = $clog2(MAX_INT + 1);
    localparam int L2_W       = INT_W + FRAC_BITS;
    localparam int LN2_W      = 28;
    localparam int SCALE_W    = 24;
    localparam int LEVEL_W    = 16;
    localparam int PROD_W     = L2_W + SCALE_W;
    localparam int R_W        = PROD_W + 1 - 32;

    // ln 2 in Q0.28
    localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065280;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_SCALE  = 2'd2;

    localparam logic signed [LEVEL_W-1:0] CLAMP_LOW_RST  = -16'sd25600;
    localparam logic signed [LEVEL_W-1:0] CLAMP_HIGH_RST = 16'sd0;
    // 20 / ln 10 in Q8.16
    localparam logic [SCALE_W-1:0]        LOG_SCALE_RST  = 24'd569238;

    // control that travels with each request down the pipeline
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             zero;
        logic [MSB_W-1:0] msb;
    } pipe_t;

endpackage

>>> src/slwc_if.sv
// ----------------------------------------------------------------------------
// slwc_if: request and result channels
// valid/ready handshake, a transfer happens when both are high at a clock edge
// ----------------------------------------------------------------------------
interface slwc_in_if;
    logic                          valid;
    logic                          ready;
    logic [slwc_pkg::IN_WIDTH-1:0] magnitude;
    logic                          last_in;

    modport source (output valid, output magnitude, output last_in, input ready);
    modport sink (input valid, input magnitude, input last_in, output ready);
endinterface

interface slwc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [slwc_pkg::LEVEL_W-1:0] level;
    logic                                last_out;

    modport source (output valid, output level, output last_out, input ready);
    modport sink (input valid, input level, input last_out, output ready);
endinterface

>>> src/slwc_norm.sv
// ----------------------------------------------------------------------------
// slwc_norm: input register and normalization
// finds the leading one of the magnitude and shifts it to bit 31
// ----------------------------------------------------------------------------
module slwc_norm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [slwc_pkg::IN_WIDTH-1:0] magnitude,
    input  logic                          last_in,
    output slwc_pkg::pipe_t               pipe_out,
    output logic [slwc_pkg::Y_W-1:0]      y_out
);

    logic                          v0_reg;
    logic                          last0_reg;
    logic [slwc_pkg::IN_WIDTH-1:0] m0_reg;

    slwc_pkg::pipe_t               pipe1_reg;
    slwc_pkg::pipe_t               pipe1_next;
    logic [slwc_pkg::IN_WIDTH-1:0] m1_reg;
    logic [slwc_pkg::MSB_W-1:0]    msb_next;

    slwc_pkg::pipe_t                        pipe2_reg;
    logic [slwc_pkg::Y_W-1:0]               y2_reg;
    logic [slwc_pkg::IN_WIDTH+30:0]         ext;
    logic [slwc_pkg::IN_WIDTH+30:0]         shifted;
    logic [slwc_pkg::Y_W-1:0]               y2_next;

    // leading one position, zero input leaves it at 0
    always_comb
    begin
        msb_next = '0;
        for (int i = 0; i < slwc_pkg::IN_WIDTH; i++)
        begin
            if (m0_reg[i])
            begin
                msb_next = slwc_pkg::MSB_W'(i);
            end
        end
        pipe1_next.valid = v0_reg;
        pipe1_next.last  = last0_reg;
        pipe1_next.zero  = (m0_reg == '0);
        pipe1_next.msb   = msb_next;
    end

    // m << 31 >> msb gives the mantissa with its top bit at 31
    always_comb
    begin
        ext     = {m1_reg, 31'b0};
        shifted = ext >> pipe1_reg.msb;
        y2_next = shifted[slwc_pkg::Y_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            pipe1_reg <= '0;
            pipe2_reg <= '0;
        end
        else if (adv)
        begin
            v0_reg    <= in_valid;
            pipe1_reg <= pipe1_next;
            pipe2_reg <= pipe1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0_reg    <= magnitude;
            last0_reg <= last_in;
            m1_reg    <= m0_reg;
            y2_reg    <= y2_next;
        end
    end

    assign pipe_out = pipe2_reg;
    assign y_out    = y2_reg;

endmodule

>>> src/slwc_cell.sv
// ----------------------------------------------------------------------------
// slwc_cell: one log2 fraction bit
// squares the mantissa, renormalizes it and shifts the carry into the fraction
// ----------------------------------------------------------------------------
module slwc_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  slwc_pkg::pipe_t                  pipe_in,
    input  logic [slwc_pkg::Y_W-1:0]         y_in,
    input  logic [slwc_pkg::FRAC_BITS-1:0]   frac_in,
    output slwc_pkg::pipe_t                  pipe_out,
    output logic [slwc_pkg::Y_W-1:0]         y_out,
    output logic [slwc_pkg::FRAC_BITS-1:0]   frac_out
);

    slwc_pkg::pipe_t                    pipe_reg;
    logic [slwc_pkg::Y_W-1:0]           y_reg;
    logic [slwc_pkg::Y_W-1:0]           y_next;
    logic [slwc_pkg::FRAC_BITS-1:0]     frac_reg;
    logic [slwc_pkg::FRAC_BITS-1:0]     frac_next;
    logic [2*slwc_pkg::Y_W-1:0]         sq;
    logic [slwc_pkg::Y_W:0]             t;

    always_comb
    begin
        sq = {{slwc_pkg::Y_W{1'b0}}, y_in} * {{slwc_pkg::Y_W{1'b0}}, y_in};
        t  = sq[2*slwc_pkg::Y_W-1:slwc_pkg::Y_W-1];
        // square reached 2.0: halve it and emit a one
        y_next    = t[slwc_pkg::Y_W] ? t[slwc_pkg::Y_W:1] : t[slwc_pkg::Y_W-1:0];
        frac_next = {frac_in[slwc_pkg::FRAC_BITS-2:0], t[slwc_pkg::Y_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_reg <= '0;
        end
        else if (adv)
        begin
            pipe_reg <= pipe_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_reg    <= y_next;
            frac_reg <= frac_next;
        end
    end

    assign pipe_out = pipe_reg;
    assign y_out    = y_reg;
    assign frac_out = frac_reg;

endmodule

>>> src/slwc_post.sv
// ----------------------------------------------------------------------------
// slwc_post: scaling, saturation and clamping
// log2 to ln, times the scale register, rounded to Q8.8, then limited
// ----------------------------------------------------------------------------
module slwc_post (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  slwc_pkg::pipe_t                      pipe_in,
    input  logic [slwc_pkg::FRAC_BITS-1:0]       frac_in,
    input  logic signed [slwc_pkg::LEVEL_W-1:0]  clamp_low,
    input  logic signed [slwc_pkg::LEVEL_W-1:0]  clamp_high,
    input  logic [slwc_pkg::SCALE_W-1:0]         log_scale,
    output logic                                 out_valid,
    output logic signed [slwc_pkg::LEVEL_W-1:0]  level,
    output logic                                 last_out
);

    typedef struct packed {
        logic valid;
        logic last;
        logic zero;
        logic neg;
    } post_t;

    post_t                                 c_reg;
    post_t                                 c_next;
    post_t                                 m1_reg;
    post_t                                 m2_reg;
    post_t                                 o_reg;

    logic [slwc_pkg::INT_W-1:0]            ipart;
    logic [slwc_pkg::L2_W-1:0]             l2_reg;
    logic [slwc_pkg::L2_W-1:0]             l2_next;
    logic [slwc_pkg::L2_W+slwc_pkg::LN2_W-1:0] ln_full;
    logic [slwc_pkg::L2_W-1:0]             ln_reg;
    logic [slwc_pkg::PROD_W-1:0]           prod_reg;
    logic [slwc_pkg::PROD_W:0]             rsum;
    logic [slwc_pkg::R_W-1:0]              r;
    logic signed [slwc_pkg::LEVEL_W-1:0]   pos_v;
    logic signed [slwc_pkg::LEVEL_W-1:0]   neg_v;
    logic signed [slwc_pkg::LEVEL_W-1:0]   v;
    logic signed [slwc_pkg::LEVEL_W-1:0]   level_reg;
    logic signed [slwc_pkg::LEVEL_W-1:0]   level_next;

    // log2(m) - 16 as magnitude and sign
    always_comb
    begin
        c_next.valid = pipe_in.valid;
        c_next.last  = pipe_in.last;
        c_next.zero  = pipe_in.zero;
        c_next.neg   = (6'(pipe_in.msb) < 6'd16);
        if (c_next.neg)
        begin
            ipart   = slwc_pkg::INT_W'(6'd16 - 6'(pipe_in.msb));
            l2_next = {ipart, {slwc_pkg::FRAC_BITS{1'b0}}}
                      - {{slwc_pkg::INT_W{1'b0}}, frac_in};
        end
        else
        begin
            ipart   = slwc_pkg::INT_W'(7'(pipe_in.msb) - 7'd16);
            l2_next = {ipart, frac_in};
        end
    end

    // times ln 2, rounded back to 24 fraction bits
    assign ln_full = ({{slwc_pkg::LN2_W{1'b0}}, l2_reg}
                      * {{slwc_pkg::L2_W{1'b0}}, slwc_pkg::LN2_Q28})
                     + (slwc_pkg::L2_W + slwc_pkg::LN2_W)'(1 << 27);

    // round away the low 32 bits of the product, saturate, clamp
    always_comb
    begin
        rsum  = {1'b0, prod_reg} + (slwc_pkg::PROD_W + 1)'(64'h8000_0000);
        r     = rsum[slwc_pkg::PROD_W:32];
        pos_v = (r > slwc_pkg::R_W'(32767)) ? 16'sh7fff : $signed(r[15:0]);
        neg_v = (r > slwc_pkg::R_W'(32768)) ? 16'sh8000 : $signed(16'd0 - r[15:0]);
        v     = m2_reg.neg ? neg_v : pos_v;
        if (m2_reg.zero || (v < clamp_low))
        begin
            v = clamp_low;
        end
        level_next = (v > clamp_high) ? clamp_high : v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg  <= '0;
            m1_reg <= '0;
            m2_reg <= '0;
            o_reg  <= '0;
        end
        else if (adv)
        begin
            c_reg  <= c_next;
            m1_reg <= c_reg;
            m2_reg <= m1_reg;
            o_reg  <= m2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l2_reg    <= l2_next;
            ln_reg    <= ln_full[slwc_pkg::L2_W+slwc_pkg::LN2_W-1:slwc_pkg::LN2_W];
            prod_reg  <= {{slwc_pkg::SCALE_W{1'b0}}, ln_reg}
                         * {{slwc_pkg::L2_W{1'b0}}, log_scale};
            level_reg <= level_next;
        end
    end

    assign out_valid = o_reg.valid;
    assign last_out  = o_reg.last;
    assign level     = level_reg;

endmodule

>>> src/scaled_log_with_clamp.sv
// ----------------------------------------------------------------------------
// scaled_log_with_clamp: clamped scaled natural log, Q16.16 in, Q8.8 out
// level = min(max(log_scale * ln(magnitude), clamp_low), clamp_high)
// ----------------------------------------------------------------------------
// din carries one request per transfer: magnitude and last_in. dout returns
// one result per request, in order: level and last_out (copy of last_in).
// A zero magnitude gives clamp_low (then limited by clamp_high).
// The config port writes clamp_low, clamp_high and log_scale by index when
// cfg_wen is high; write it only while no request is in flight.
// The request enters the first of 31 registers at the accepting edge and
// moves on through three input and normalization stages, a chain of 24
// squaring cells (one log2 fraction bit each, one 32x32 multiply per cell)
// and four stages of scaling, rounding and clamping.
// Throughput is one request per cycle. When dout is stalled the whole
// pipeline holds and din.ready drops; the result register frees up as soon
// as dout.ready returns.
// Reset clears all stage valids and loads clamp_low = -100.0,
// clamp_high = 0.0, log_scale = 20/ln10.
// ----------------------------------------------------------------------------
module scaled_log_with_clamp (
    input  logic                             clk,
    input  logic                             rst_n,
    slwc_in_if.sink                          din,
    slwc_out_if.source                       dout,
    input  logic                             cfg_wen,
    input  logic [slwc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slwc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                                   adv;
    logic signed [slwc_pkg::LEVEL_W-1:0]    clamp_low_reg;
    logic signed [slwc_pkg::LEVEL_W-1:0]    clamp_high_reg;
    logic [slwc_pkg::SCALE_W-1:0]           log_scale_reg;

    slwc_pkg::pipe_t                        chain_pipe [0:slwc_pkg::FRAC_BITS];
    logic [slwc_pkg::Y_W-1:0]               chain_y    [0:slwc_pkg::FRAC_BITS];
    logic [slwc_pkg::FRAC_BITS-1:0]         chain_frac [0:slwc_pkg::FRAC_BITS];

    // everything moves unless a finished result is waiting
    assign adv       = !dout.valid || dout.ready;
    assign din.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_low_reg  <= slwc_pkg::CLAMP_LOW_RST;
            clamp_high_reg <= slwc_pkg::CLAMP_HIGH_RST;
            log_scale_reg  <= slwc_pkg::LOG_SCALE_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                slwc_pkg::REG_CLAMP_LOW:
                begin
                    clamp_low_reg <= $signed(cfg_data[slwc_pkg::LEVEL_W-1:0]);
                end
                slwc_pkg::REG_CLAMP_HIGH:
                begin
                    clamp_high_reg <= $signed(cfg_data[slwc_pkg::LEVEL_W-1:0]);
                end
                slwc_pkg::REG_LOG_SCALE:
                begin
                    log_scale_reg <= cfg_data[slwc_pkg::SCALE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    slwc_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (din.valid),
        .magnitude (din.magnitude),
        .last_in   (din.last_in),
        .pipe_out  (chain_pipe[0]),
        .y_out     (chain_y[0])
    );

    assign chain_frac[0] = '0;

    for (genvar g = 0; g < slwc_pkg::FRAC_BITS; g++)
    begin : g_cell
        slwc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .pipe_in  (chain_pipe[g]),
            .y_in     (chain_y[g]),
            .frac_in  (chain_frac[g]),
            .pipe_out (chain_pipe[g+1]),
            .y_out    (chain_y[g+1]),
            .frac_out (chain_frac[g+1])
        );
    end

    slwc_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .pipe_in    (chain_pipe[slwc_pkg::FRAC_BITS]),
        .frac_in    (chain_frac[slwc_pkg::FRAC_BITS]),
        .clamp_low  (clamp_low_reg),
        .clamp_high (clamp_high_reg),
        .log_scale  (log_scale_reg),
        .out_valid  (dout.valid),
        .level      (dout.level),
        .last_out   (dout.last_out)
    );

    // a stalled result blocks new requests
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.ready) |-> !din.ready)
        else $error("request accepted while result stalled");

    // normalized mantissa of a nonzero request has its leading one at bit 31
    a_norm_leading_one: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_pipe[0].valid && !chain_pipe[0].zero) |-> chain_y[0][slwc_pkg::Y_W-1])
        else $error("normalization lost the leading one");

    // squaring keeps the mantissa in [1, 2), checked at the end of the chain
    a_chain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_pipe[slwc_pkg::FRAC_BITS].valid && !chain_pipe[slwc_pkg::FRAC_BITS].zero)
        |-> chain_y[slwc_pkg::FRAC_BITS][slwc_pkg::Y_W-1])
        else $error("cell chain mantissa out of range");

    // a held stage keeps its request
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(chain_pipe[slwc_pkg::FRAC_BITS]))
        else $error("cell chain moved during a stall");

endmodule

>>> tb/tb_scaled_log_with_clamp.sv
// ----------------------------------------------------------------------------
// tb_scaled_log_with_clamp: self-checking bench for the clamped scaled log
// streams magnitudes through the block under several limit and scale
// settings: a short directed table (reset values, zero, input extremes,
// zero scale, saturation, crossed limits), then random phases with random
// settings, checked against typed levels or a bit-level log2 predictor
// ----------------------------------------------------------------------------
module tb_scaled_log_with_clamp;

    localparam int PIPE_LATENCY = 30;
    localparam int TOTAL_ITEMS  = 850;
    localparam int CALM_FROM    = 770;
    localparam int LONG_HOLD    = 80;
    localparam int N_DIR        = 22;
    // far beyond the slowest legal run
    localparam int RUN_LIMIT    = 2400000;

    // index with no register behind it
    localparam logic [slwc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [slwc_pkg::LEVEL_W-1:0] lo;
        logic signed [slwc_pkg::LEVEL_W-1:0] hi;
        logic [slwc_pkg::SCALE_W-1:0]        scale;
    } setting_t;

    typedef struct packed {
        int                                  cfg_id;
        logic [slwc_pkg::IN_WIDTH-1:0]       mag;
        logic                                last;
        logic                                typed;
        logic signed [slwc_pkg::LEVEL_W-1:0] level;
    } dir_row_t;

    typedef struct {
        logic signed [slwc_pkg::LEVEL_W-1:0] level;
        logic                                last;
        bit                                  exact;
    } level_exp_t;

    localparam setting_t DIR_SETTINGS [4] = '{
        '{slwc_pkg::CLAMP_LOW_RST, slwc_pkg::CLAMP_HIGH_RST, slwc_pkg::LOG_SCALE_RST},
        '{16'sh8000, 16'sh7FFF, 24'hFFFFFF},
        '{16'sh8000, 16'sh7FFF, 24'h000000},
        '{16'sd256, -16'sd256, slwc_pkg::LOG_SCALE_RST}
    };

    // typed levels where the answer is obvious, the rest go to the predictor
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{0, 32'h0000_0000, 1'b0, 1'b1, -16'sd25600},
        '{0, 32'h0001_0000, 1'b1, 1'b1, 16'sd0},
        '{0, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'sd0},
        '{0, 32'h8000_0000, 1'b1, 1'b1, 16'sd0},
        '{0, 32'h0000_0001, 1'b0, 1'b0, 16'sd0},
        '{0, 32'h0000_8000, 1'b1, 1'b0, 16'sd0},
        '{0, 32'h0000_FFFF, 1'b0, 1'b0, 16'sd0},
        '{0, 32'h0000_0A3C, 1'b1, 1'b0, 16'sd0},
        '{1, 32'h0000_0000, 1'b0, 1'b1, 16'sh8000},
        '{1, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'sh7FFF},
        '{1, 32'h0000_0001, 1'b0, 1'b1, 16'sh8000},
        '{1, 32'h0001_0000, 1'b1, 1'b1, 16'sd0},
        '{1, 32'h0001_0001, 1'b0, 1'b0, 16'sd0},
        '{1, 32'h0000_FFFF, 1'b1, 1'b0, 16'sd0},
        '{2, 32'h0000_0000, 1'b0, 1'b1, 16'sh8000},
        '{2, 32'h0000_0001, 1'b1, 1'b1, 16'sd0},
        '{2, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'sd0},
        '{2, 32'h0001_2345, 1'b1, 1'b1, 16'sd0},
        '{3, 32'h0000_0000, 1'b0, 1'b1, -16'sd256},
        '{3, 32'h0001_0000, 1'b1, 1'b1, -16'sd256},
        '{3, 32'hFFFF_FFFF, 1'b0, 1'b1, -16'sd256},
        '{3, 32'h0000_0001, 1'b1, 1'b1, -16'sd256}
    };

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wen;
    logic [slwc_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [slwc_pkg::CFG_DATA_W-1:0]  cfg_data;

    slwc_in_if  in_ch ();
    slwc_out_if out_ch ();

    scaled_log_with_clamp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (in_ch),
        .dout      (out_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies as the block should hold them
    logic signed [slwc_pkg::LEVEL_W-1:0] cur_lo;
    logic signed [slwc_pkg::LEVEL_W-1:0] cur_hi;
    logic [slwc_pkg::SCALE_W-1:0]        cur_scale;

    level_exp_t pending_levels [$];

    int  fail_count      = 0;
    int  results_checked = 0;
    int  stall_cycles    = 0;
    int  long_holds_asked = 0;
    int  items_sent;
    int  settings_used;
    int  src_idle_pct;
    int  snk_idle_pct;
    bit  calm;

    function automatic logic signed [slwc_pkg::LEVEL_W-1:0] scaled_log_level(
        input logic [slwc_pkg::IN_WIDTH-1:0]       mag,
        input logic signed [slwc_pkg::LEVEL_W-1:0] lo,
        input logic signed [slwc_pkg::LEVEL_W-1:0] hi,
        input logic [slwc_pkg::SCALE_W-1:0]        scale
    );
        int          msb;
        int          i;
        int          v;
        bit          below_one;
        logic [63:0] m;
        logic [63:0] y;
        logic [63:0] frac;
        logic [63:0] l2;
        logic [63:0] ln24;
        logic [63:0] prod;
        logic [63:0] r;
        m = 64'(mag);
        if (m == 64'd0)
        begin
            v = int'(lo);
        end
        else
        begin
            msb = 63;
            while (msb > 0 && !m[msb])
                msb--;
            if (msb >= 31)
                y = m >> (msb - 31);
            else
                y = m << (31 - msb);
            // one fraction bit of log2 per squaring of the normalized mantissa
            frac = 64'd0;
            for (i = 0; i < slwc_pkg::FRAC_BITS; i++)
            begin
                y = (y * y) >> 31;
                frac = frac << 1;
                if (y >= 64'h1_0000_0000)
                begin
                    y = y >> 1;
                    frac[0] = 1'b1;
                end
            end
            // log2 relative to 1.0, which sits at bit 16
            if (msb >= 16)
            begin
                below_one = 1'b0;
                l2 = (64'(msb - 16) << slwc_pkg::FRAC_BITS) + frac;
            end
            else
            begin
                below_one = 1'b1;
                l2 = (64'(16 - msb) << slwc_pkg::FRAC_BITS) - frac;
            end
            ln24 = (l2 * 64'(slwc_pkg::LN2_Q28) + (64'd1 << 27)) >> 28;
            prod = ln24 * 64'(scale);
            r = (prod + (64'd1 << 31)) >> 32;
            if (below_one)
                v = (r > 64'd32768) ? -32768 : -int'(r);
            else
                v = (r > 64'd32767) ? 32767 : int'(r);
            if (v < int'(lo))
                v = int'(lo);
        end
        if (v > int'(hi))
            v = int'(hi);
        return slwc_pkg::LEVEL_W'(v);
    endfunction

    function automatic logic [slwc_pkg::IN_WIDTH-1:0] random_magnitude();
        logic [slwc_pkg::IN_WIDTH-1:0] mag;
        case ($urandom_range(0, 9))
            0: mag = '0;
            1: mag = $urandom;
            2: mag = 32'h0001_0000 + $urandom_range(0, 64) - 32;
            3: mag = 32'd1 << $urandom_range(0, 31);
            4: mag = 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: mag = $urandom >> $urandom_range(0, 31);
        endcase
        return mag;
    endfunction

    function automatic setting_t random_setting();
        setting_t s;
        case ($urandom_range(0, 5))
            0:
            begin
                s.lo    = slwc_pkg::LEVEL_W'($urandom);
                s.hi    = slwc_pkg::LEVEL_W'($urandom);
                s.scale = slwc_pkg::SCALE_W'($urandom);
            end
            1:
            begin
                s.lo    = 16'sh8000;
                s.hi    = 16'sh7FFF;
                s.scale = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            end
            default:
            begin
                s.lo = slwc_pkg::LEVEL_W'(-int'($urandom_range(0, 32768)));
                s.hi = slwc_pkg::LEVEL_W'($urandom_range(0, 32767));
                case ($urandom_range(0, 2))
                    0: s.scale = slwc_pkg::SCALE_W'($urandom);
                    1: s.scale = slwc_pkg::SCALE_W'($urandom_range(0, 1 << 20));
                    default: s.scale = slwc_pkg::SCALE_W'(slwc_pkg::LOG_SCALE_RST
                                       + $urandom_range(0, 2000) - 1000);
                endcase
            end
        endcase
        return s;
    endfunction

    task automatic write_reg(input logic [slwc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slwc_pkg::CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            slwc_pkg::REG_CLAMP_LOW:  cur_lo = data[slwc_pkg::LEVEL_W-1:0];
            slwc_pkg::REG_CLAMP_HIGH: cur_hi = data[slwc_pkg::LEVEL_W-1:0];
            slwc_pkg::REG_LOG_SCALE:  cur_scale = data[slwc_pkg::SCALE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_setting(input setting_t s, input bit spare);
        write_reg(slwc_pkg::REG_CLAMP_LOW, {8'($urandom), s.lo});
        write_reg(slwc_pkg::REG_CLAMP_HIGH, {8'($urandom), s.hi});
        write_reg(slwc_pkg::REG_LOG_SCALE, s.scale);
        if (spare)
            write_reg(REG_SPARE, 24'($urandom));
        cfg_wen <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        while (pending_levels.size() != 0)
            @(negedge clk);
    endtask

    // offer one request and log what it should give once it is taken
    task automatic send_request(input logic [slwc_pkg::IN_WIDTH-1:0]       mag,
                                input logic                                last,
                                input logic                                typed,
                                input logic signed [slwc_pkg::LEVEL_W-1:0] level);
        level_exp_t e;
        if (!calm && $urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.magnitude <= mag;
        in_ch.last_in   <= last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        e.level = typed ? level : scaled_log_level(mag, cur_lo, cur_hi, cur_scale);
        e.last  = last;
        e.exact = typed || (mag == '0);
        pending_levels.push_back(e);
        items_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // result side: random ready bursts, plus one long hold-off on request
    initial
    begin
        int idle_left;
        int long_holds_done;
        idle_left       = 0;
        long_holds_done = 0;
        out_ch.ready    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_holds_done != long_holds_asked)
            begin
                long_holds_done = long_holds_asked;
                idle_left       = LONG_HOLD;
            end
            else if (idle_left == 0 && !calm && $urandom_range(0, 99) < snk_idle_pct)
            begin
                idle_left = $urandom_range(1, 9);
            end
            if (idle_left > 0)
            begin
                out_ch.ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        level_exp_t e;
        int diff;
        if (rst_n)
        begin
            if (in_ch.valid && !in_ch.ready)
                stall_cycles++;
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_levels.size() == 0)
                begin
                    $error("result with no request pending: level %0d", out_ch.level);
                    fail_count++;
                end
                else
                begin
                    e = pending_levels.pop_front();
                    results_checked++;
                    diff = int'(out_ch.level) - int'(e.level);
                    if (e.exact ? (diff != 0) : (diff > 1 || diff < -1))
                    begin
                        $error("level: expected %0d, got %0d", e.level, out_ch.level);
                        fail_count++;
                    end
                    if (out_ch.last_out !== e.last)
                    begin
                        $error("last_out: expected %0b, got %0b", e.last, out_ch.last_out);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int cur_id;
        int k;
        int j;
        int phase_len;
        int phase_no;
        rst_n           = 1'b0;
        cfg_wen         = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.magnitude = '0;
        in_ch.last_in   = 1'b0;
        cur_lo          = slwc_pkg::CLAMP_LOW_RST;
        cur_hi          = slwc_pkg::CLAMP_HIGH_RST;
        cur_scale       = slwc_pkg::LOG_SCALE_RST;
        items_sent      = 0;
        settings_used   = 1;
        src_idle_pct    = 20;
        snk_idle_pct    = 20;
        calm            = 1'b0;
        cur_id          = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, the first block of rows runs on reset values
        for (k = 0; k < N_DIR; k++)
        begin
            if (DIR_ROWS[k].cfg_id != cur_id)
            begin
                in_ch.valid <= 1'b0;
                drain();
                cur_id = DIR_ROWS[k].cfg_id;
                apply_setting(DIR_SETTINGS[cur_id], cur_id == 3);
            end
            send_request(DIR_ROWS[k].mag, DIR_ROWS[k].last, DIR_ROWS[k].typed,
                         DIR_ROWS[k].level);
        end
        in_ch.valid <= 1'b0;

        phase_no = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            drain();
            apply_setting(random_setting(), $urandom_range(0, 2) == 0);
            case ($urandom_range(0, 3))
                0: src_idle_pct = 0;
                1: src_idle_pct = 10;
                2: src_idle_pct = 30;
                default: src_idle_pct = 60;
            endcase
            case ($urandom_range(0, 3))
                0: snk_idle_pct = 0;
                1: snk_idle_pct = 10;
                2: snk_idle_pct = 30;
                default: snk_idle_pct = 60;
            endcase
            // keep offering while the result side sits still long enough to fill the pipe
            if (phase_no == 1)
            begin
                src_idle_pct = 0;
                long_holds_asked++;
            end
            phase_len = $urandom_range(60, 140);
            for (j = 0; j < phase_len && items_sent < TOTAL_ITEMS; j++)
            begin
                calm = (items_sent >= CALM_FROM);
                send_request(random_magnitude(), 1'($urandom_range(0, 1)), 1'b0, '0);
            end
            in_ch.valid <= 1'b0;
            phase_no++;
        end

        drain();
        repeat (PIPE_LATENCY + 8) @(negedge clk);
        $display("run covered %0d requests under %0d register settings, %0d results checked",
                 items_sent, settings_used, results_checked);
        $display("input held off for %0d cycles while the result side stalled", stall_cycles);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
src/slwc_pkg.sv
src/slwc_if.sv
src/slwc_norm.sv
src/slwc_cell.sv
src/slwc_post.sv
src/scaled_log_with_clamp.sv
tb/tb_scaled_log_with_clamp.sv
